FILE: hdl/psp_pkg.sv
// Shared types, constants and helper functions for the path shape point emitter.
// Used by psp_front, psp_queue, psp_back and path_shape_point_emitter.
package psp_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int COORD_W = 24;
    localparam int SUM_W   = COORD_W + 1;   // corner plus size, exact
    localparam int BASE_W  = COORD_W + 3;   // doubled center plus rounding one
    localparam int PROD_W  = 48;            // K times size
    localparam int ACC_W   = 52;            // coordinate in 2^-25 LSB units
    localparam int FRAC_W  = 25;
    localparam int IDX_W   = 4;

    // 0.552285 in unsigned Q0.24
    localparam logic [23:0] ELL_K = 24'd9265805;

    typedef enum logic [2:0] {
        CMD_LINE    = 3'd0,
        CMD_BEZIER  = 3'd1,
        CMD_RECT    = 3'd2,
        CMD_ELLIPSE = 3'd3,
        CMD_START   = 3'd4
    } cmd_code_t;

    localparam logic [7:0] PT_START  = 8'h00;
    localparam logic [7:0] PT_LINE   = 8'h01;
    localparam logic [7:0] PT_BEZIER = 8'h03;
    localparam logic [7:0] PT_CLOSE  = 8'h80;

    // offset applied to the ellipse center for one coordinate
    typedef enum logic [2:0] {
        OFF_ZERO,
        OFF_RAD_POS,
        OFF_RAD_NEG,
        OFF_K_POS,
        OFF_K_NEG
    } ell_off_t;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic signed [COORD_W-1:0] p4_x;
        logic signed [COORD_W-1:0] p4_y;
    } cmd_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [7:0]                point_kind;
        logic                      last_of_command;
    } point_item_t;

    // classified command as held between front and back
    typedef struct packed {
        cmd_code_t                 kind;
        logic                      force_start;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] x3;
        logic signed [COORD_W-1:0] y3;
        logic signed [COORD_W-1:0] x4;
        logic signed [COORD_W-1:0] y4;
        logic signed [SUM_W-1:0]   sum_x;
        logic signed [SUM_W-1:0]   sum_y;
        logic signed [BASE_W-1:0]  ctr_x;
        logic signed [BASE_W-1:0]  ctr_y;
        logic signed [PROD_W-1:0]  k_x;
        logic signed [PROD_W-1:0]  k_y;
    } draw_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [IDX_W-1:0] last_index(input cmd_code_t kind);
        case (kind)
            CMD_LINE:    last_index = IDX_W'(1);
            CMD_BEZIER:  last_index = IDX_W'(3);
            CMD_RECT:    last_index = IDX_W'(3);
            CMD_ELLIPSE: last_index = IDX_W'(12);
            default:     last_index = '0;
        endcase
    endfunction

    function automatic ell_off_t ell_x_sel(input logic [IDX_W-1:0] idx);
        case (idx)
            4'd0, 4'd1, 4'd11, 4'd12: ell_x_sel = OFF_RAD_POS;
            4'd2, 4'd10:              ell_x_sel = OFF_K_POS;
            4'd4, 4'd8:               ell_x_sel = OFF_K_NEG;
            4'd5, 4'd6, 4'd7:         ell_x_sel = OFF_RAD_NEG;
            default:                  ell_x_sel = OFF_ZERO;
        endcase
    endfunction

    function automatic ell_off_t ell_y_sel(input logic [IDX_W-1:0] idx);
        case (idx)
            4'd1, 4'd5:               ell_y_sel = OFF_K_NEG;
            4'd2, 4'd3, 4'd4:         ell_y_sel = OFF_RAD_NEG;
            4'd7, 4'd11:              ell_y_sel = OFF_K_POS;
            4'd8, 4'd9, 4'd10:        ell_y_sel = OFF_RAD_POS;
            default:                  ell_y_sel = OFF_ZERO;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [BASE_W-1:0] v
    );
        logic signed [BASE_W-1:0] hi;
        logic signed [BASE_W-1:0] lo;
        hi = BASE_W'((1 << (COORD_W - 1)) - 1);
        lo = -BASE_W'(1 << (COORD_W - 1));
        if (v > hi)
            sat_coord = hi[COORD_W-1:0];
        else if (v < lo)
            sat_coord = lo[COORD_W-1:0];
        else
            sat_coord = v[COORD_W-1:0];
    endfunction

    // value already carries the half-LSB bias, so rounding is a floor shift
    function automatic logic signed [COORD_W-1:0] round_coord(
        input logic signed [ACC_W-1:0] acc
    );
        round_coord = sat_coord(acc[ACC_W-1:FRAC_W]);
    endfunction

endpackage

FILE: hdl/psp_front.sv
// Front end: accepts commands, tracks figure state, precomputes sums and
// ellipse products. Depends on psp_pkg.
module psp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  psp_pkg::cmd_item_t    cmd,
    input  psp_pkg::queue_status_t q_status,
    output logic                  push,
    output psp_pkg::draw_entry_t  entry
);
    import psp_pkg::*;

    logic start_pending_reg, start_pending_next;
    logic last_closed_reg, last_closed_next;
    logic accept;
    logic is_draw;
    logic signed [PROD_W:0] prod_x;
    logic signed [PROD_W:0] prod_y;

    always_comb
    begin
        cmd_stall = q_status.full;
        accept    = cmd_valid && !cmd_stall;

        is_draw            = 1'b0;
        start_pending_next = start_pending_reg;
        last_closed_next   = last_closed_reg;
        case (cmd_code_t'(cmd.command))
            CMD_LINE, CMD_BEZIER:
            begin
                is_draw            = 1'b1;
                start_pending_next = 1'b0;
                last_closed_next   = 1'b0;
            end
            CMD_RECT:
            begin
                is_draw            = 1'b1;
                start_pending_next = 1'b0;
                last_closed_next   = 1'b1;
            end
            CMD_ELLIPSE:
            begin
                is_draw            = 1'b1;
                start_pending_next = 1'b1;
                last_closed_next   = 1'b1;
            end
            CMD_START:
            begin
                start_pending_next = 1'b1;
            end
            default:
            begin
                is_draw = 1'b0;
            end
        endcase
        if (!accept)
        begin
            start_pending_next = start_pending_reg;
            last_closed_next   = last_closed_reg;
        end
        push = accept && is_draw;
    end

    always_comb
    begin
        prod_x = $signed({1'b0, ELL_K}) * cmd.p2_x;
        prod_y = $signed({1'b0, ELL_K}) * cmd.p2_y;

        entry.kind        = cmd_code_t'(cmd.command);
        entry.force_start = start_pending_reg || last_closed_reg;
        entry.x1 = cmd.p1_x;
        entry.y1 = cmd.p1_y;
        entry.x2 = cmd.p2_x;
        entry.y2 = cmd.p2_y;
        entry.x3 = cmd.p3_x;
        entry.y3 = cmd.p3_y;
        entry.x4 = cmd.p4_x;
        entry.y4 = cmd.p4_y;
        entry.sum_x = {cmd.p1_x[COORD_W-1], cmd.p1_x} + {cmd.p2_x[COORD_W-1], cmd.p2_x};
        entry.sum_y = {cmd.p1_y[COORD_W-1], cmd.p1_y} + {cmd.p2_y[COORD_W-1], cmd.p2_y};
        // doubled center plus one: 2*corner + size + 1
        entry.ctr_x = {{2{cmd.p1_x[COORD_W-1]}}, cmd.p1_x, 1'b0}
                    + {{3{cmd.p2_x[COORD_W-1]}}, cmd.p2_x} + BASE_W'(1);
        entry.ctr_y = {{2{cmd.p1_y[COORD_W-1]}}, cmd.p1_y, 1'b0}
                    + {{3{cmd.p2_y[COORD_W-1]}}, cmd.p2_y} + BASE_W'(1);
        entry.k_x = prod_x[PROD_W-1:0];
        entry.k_y = prod_y[PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pending_reg <= 1'b1;
            last_closed_reg   <= 1'b0;
        end
        else
        begin
            start_pending_reg <= start_pending_next;
            last_closed_reg   <= last_closed_next;
        end
    end

endmodule

FILE: hdl/psp_queue.sv
// Short FIFO of classified commands between front and back.
// Depends on psp_pkg.
module psp_queue #(
    parameter int DEPTH = psp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  psp_pkg::draw_entry_t   din,
    input  logic                   pop,
    output psp_pkg::draw_entry_t   dout,
    output psp_pkg::queue_status_t status
);
    import psp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    draw_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    always_comb
    begin
        status.full  = (count_reg == CNT_W'(DEPTH));
        status.empty = (count_reg == '0);
        do_push = push && !status.full;
        do_pop  = pop && !status.empty;
        dout    = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/psp_back.sv
// Back end: steps through the points of the head command, one per cycle
// while pt is not stalled, into the output register. Depends on psp_pkg.
module psp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psp_pkg::draw_entry_t   head,
    input  psp_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   pt_valid,
    input  logic                   pt_stall,
    output psp_pkg::point_item_t   pt
);
    import psp_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pt_valid_reg, pt_valid_next;
    point_item_t      pt_reg;
    point_item_t      point;
    logic             load, emit, is_last;
    logic signed [SUM_W-1:0]  vx, vy;
    logic signed [BASE_W-1:0] base_x, base_y;
    ell_off_t         sel_x, sel_y;
    logic signed [ACC_W-1:0]  acc_x, acc_y;
    logic signed [ACC_W-1:0]  kx_ext, ky_ext;
    logic [7:0]       kind;

    always_comb
    begin
        is_last = (idx_reg == last_index(head.kind));
        load    = !pt_valid_reg || !pt_stall;
        emit    = !q_status.empty && load;
        pop     = emit && is_last;

        vx    = {head.x1[COORD_W-1], head.x1};
        vy    = {head.y1[COORD_W-1], head.y1};
        sel_x = OFF_ZERO;
        sel_y = OFF_ZERO;
        kind  = PT_LINE;
        case (head.kind)
            CMD_LINE:
            begin
                if (idx_reg != '0)
                begin
                    vx = {head.x2[COORD_W-1], head.x2};
                    vy = {head.y2[COORD_W-1], head.y2};
                end
            end
            CMD_BEZIER:
            begin
                case (idx_reg)
                    4'd0:
                    begin
                        kind = PT_LINE;
                    end
                    4'd1:
                    begin
                        vx   = {head.x2[COORD_W-1], head.x2};
                        vy   = {head.y2[COORD_W-1], head.y2};
                        kind = PT_BEZIER;
                    end
                    4'd2:
                    begin
                        vx   = {head.x3[COORD_W-1], head.x3};
                        vy   = {head.y3[COORD_W-1], head.y3};
                        kind = PT_BEZIER;
                    end
                    default:
                    begin
                        vx   = {head.x4[COORD_W-1], head.x4};
                        vy   = {head.y4[COORD_W-1], head.y4};
                        kind = PT_BEZIER;
                    end
                endcase
            end
            CMD_RECT:
            begin
                case (idx_reg)
                    4'd0:
                    begin
                        kind = PT_START;
                    end
                    4'd1:
                    begin
                        vx = head.sum_x;
                    end
                    4'd2:
                    begin
                        vx = head.sum_x;
                        vy = head.sum_y;
                    end
                    default:
                    begin
                        vy   = head.sum_y;
                        kind = PT_LINE | PT_CLOSE;
                    end
                endcase
            end
            CMD_ELLIPSE:
            begin
                sel_x = ell_x_sel(idx_reg);
                sel_y = ell_y_sel(idx_reg);
                if (idx_reg == '0)
                    kind = PT_START;
                else if (is_last)
                    kind = PT_BEZIER | PT_CLOSE;
                else
                    kind = PT_BEZIER;
            end
            default:
            begin
                kind = PT_LINE;
            end
        endcase

        // exact point p maps to 2p+1, the half-LSB bias of the rounding
        base_x = {vx[SUM_W-1], vx, 1'b1};
        base_y = {vy[SUM_W-1], vy, 1'b1};
        if (head.kind == CMD_ELLIPSE)
        begin
            case (sel_x)
                OFF_RAD_POS: base_x = {head.sum_x[SUM_W-1], head.sum_x, 1'b1};
                OFF_RAD_NEG: base_x = {{2{head.x1[COORD_W-1]}}, head.x1, 1'b1};
                default:     base_x = head.ctr_x;
            endcase
            case (sel_y)
                OFF_RAD_POS: base_y = {head.sum_y[SUM_W-1], head.sum_y, 1'b1};
                OFF_RAD_NEG: base_y = {{2{head.y1[COORD_W-1]}}, head.y1, 1'b1};
                default:     base_y = head.ctr_y;
            endcase
        end

        kx_ext = {{(ACC_W - PROD_W){head.k_x[PROD_W-1]}}, head.k_x};
        ky_ext = {{(ACC_W - PROD_W){head.k_y[PROD_W-1]}}, head.k_y};
        acc_x  = {base_x[BASE_W-1], base_x, 24'b0};
        acc_y  = {base_y[BASE_W-1], base_y, 24'b0};
        case (sel_x)
            OFF_K_POS: acc_x = acc_x + kx_ext;
            OFF_K_NEG: acc_x = acc_x - kx_ext;
            default:   acc_x = acc_x;
        endcase
        case (sel_y)
            OFF_K_POS: acc_y = acc_y + ky_ext;
            OFF_K_NEG: acc_y = acc_y - ky_ext;
            default:   acc_y = acc_y;
        endcase

        // first point of a figure after a start request or a close
        if (idx_reg == '0 && head.force_start)
            kind = PT_START;

        point.out_x           = round_coord(acc_x);
        point.out_y           = round_coord(acc_y);
        point.point_kind      = kind;
        point.last_of_command = is_last;

        idx_next = idx_reg;
        if (emit)
            idx_next = is_last ? '0 : idx_reg + IDX_W'(1);
        pt_valid_next = load ? !q_status.empty : pt_valid_reg;

        pt_valid = pt_valid_reg;
        pt       = pt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            pt_reg <= point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            pt_valid_reg <= pt_valid_next;
        end
    end

endmodule

FILE: hdl/path_shape_point_emitter.sv
// Top level of the path shape point emitter: front, command queue and back.
// Depends on psp_pkg, psp_front, psp_queue and psp_back.
//
// One drawing command per cmd transaction turns into path points on the pt
// channel, each with a type byte (0 start, 1 line, 3 bezier, 0x80 close).
// A line gives 2 points, a bezier 4, a rectangle 4 (close on the last) and an
// ellipse 13 (start point plus four cubic quadrants, close on the last).
// Rectangle and ellipse take the corner in p1 and the size in p2; a
// start-figure command gives no points and codes 5 to 7 are ignored. The
// first point after a start request or a closed figure is typed Start.
// Rate: the back sequencer sends one point per cycle while pt is not stalled,
// so an ellipse, with the most points, sets the sustained command rate. The
// front takes a command whenever the queue of QUEUE_DEPTH entries has room,
// start-figure commands included, so consecutive commands run back to back
// with no bubble on the pt channel. An accepted command is written into the
// queue, and its first point then leaves through the back's output register.
// Coordinates are signed Q16.8; ellipse points round to nearest (ties up)
// and all points saturate to 24 bits.
module path_shape_point_emitter #(
    parameter int QUEUE_DEPTH = psp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  psp_pkg::cmd_item_t   cmd,
    output logic                 pt_valid,
    input  logic                 pt_stall,
    output psp_pkg::point_item_t pt
);
    import psp_pkg::*;

    // front to queue
    logic          push;
    draw_entry_t   push_entry;
    // queue to back
    draw_entry_t   head_entry;
    queue_status_t q_status;
    logic          pop;

    psp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_status  (q_status),
        .push      (push),
        .entry     (push_entry)
    );

    psp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (push_entry),
        .pop    (pop),
        .dout   (head_entry),
        .status (q_status)
    );

    psp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_entry),
        .q_status (q_status),
        .pop      (pop),
        .pt_valid (pt_valid),
        .pt_stall (pt_stall),
        .pt       (pt)
    );

`ifndef SYNTHESIS
    // a close bit only ever sits on the final point of a command
    a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && pt.point_kind[7] |-> pt.last_of_command)
        else $error("close bit on a point that is not last of its command");

    // points of one command follow each other with no gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && !pt_stall && !pt.last_of_command |=> pt_valid)
        else $error("gap inside the points of one command");

    // the queue only fills after a command was offered
    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_stall) |-> $past(cmd_valid))
        else $error("queue became full without a pushed command");
`endif

endmodule

FILE: sim/psp_point_checker.sv
// Checker for the path shape point emitter: predicts the points of every
// accepted command and compares them with the points taken off the pt channel.
// Depends on psp_pkg for the transaction types, command codes and type bytes.
module psp_point_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  psp_pkg::cmd_item_t   cmd,
    input  logic                 pt_valid,
    input  logic                 pt_stall,
    input  psp_pkg::point_item_t pt,
    output int                   mismatches,
    output int                   points_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import psp_pkg::*;

    localparam longint FRAC_HALF = longint'(1) << (FRAC_W - 1);
    localparam longint FRAC_ONE  = longint'(1) << FRAC_W;

    point_item_t expected_points[$];
    logic        start_pending = 1'b1;
    logic        last_closed   = 1'b0;

    initial
    begin
        mismatches         = 0;
        points_outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > longint'(8388607))
            return 24'sh7FFFFF;
        if (v < -longint'(8388608))
            return 24'sh800000;
        return COORD_W'(v);
    endfunction

    // 2^-25 LSB units to LSB, nearest with ties upward
    function automatic longint round_lsb(input longint v);
        return (v + FRAC_HALF) >>> FRAC_W;
    endfunction

    // ellipse walks clockwise from the right-hand point, three points per quadrant
    function automatic longint x_offset(input int idx, input longint rad, input longint kt);
        case (idx)
            0, 1, 11, 12: return rad;
            2, 10:        return kt;
            4, 8:         return -kt;
            5, 6, 7:      return -rad;
            default:      return 0;
        endcase
    endfunction

    function automatic longint y_offset(input int idx, input longint rad, input longint kt);
        case (idx)
            1, 5:     return -kt;
            2, 3, 4:  return -rad;
            7, 11:    return kt;
            8, 9, 10: return rad;
            default:  return 0;
        endcase
    endfunction

    // a pending start or a closed figure turns the next point into Start
    task automatic add_point(input longint x, input longint y, input logic [7:0] nominal,
                             input logic is_last, input logic close_after);
        point_item_t p;
        logic [7:0]  kind;
        kind          = (start_pending || last_closed) ? PT_START : nominal;
        start_pending = 1'b0;
        last_closed   = kind[7];
        p.out_x           = clamp_coord(x);
        p.out_y           = clamp_coord(y);
        p.point_kind      = close_after ? (kind | PT_CLOSE) : kind;
        p.last_of_command = is_last;
        expected_points.push_back(p);
    endtask

    task automatic predict_points(input cmd_item_t c);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint rx, ry, cx, cy, kx, ky;
        x1 = longint'(c.p1_x);
        y1 = longint'(c.p1_y);
        x2 = longint'(c.p2_x);
        y2 = longint'(c.p2_y);
        x3 = longint'(c.p3_x);
        y3 = longint'(c.p3_y);
        x4 = longint'(c.p4_x);
        y4 = longint'(c.p4_y);
        case (c.command)
            CMD_LINE:
            begin
                add_point(x1, y1, PT_LINE, 1'b0, 1'b0);
                add_point(x2, y2, PT_LINE, 1'b1, 1'b0);
            end
            CMD_BEZIER:
            begin
                add_point(x1, y1, PT_LINE, 1'b0, 1'b0);
                add_point(x2, y2, PT_BEZIER, 1'b0, 1'b0);
                add_point(x3, y3, PT_BEZIER, 1'b0, 1'b0);
                add_point(x4, y4, PT_BEZIER, 1'b1, 1'b0);
            end
            CMD_RECT:
            begin
                add_point(x1, y1, PT_START, 1'b0, 1'b0);
                add_point(x1 + x2, y1, PT_LINE, 1'b0, 1'b0);
                add_point(x1 + x2, y1 + y2, PT_LINE, 1'b0, 1'b0);
                add_point(x1, y1 + y2, PT_LINE | PT_CLOSE, 1'b1, 1'b0);
            end
            CMD_ELLIPSE:
            begin
                rx = x2 * FRAC_HALF;
                ry = y2 * FRAC_HALF;
                cx = x1 * FRAC_ONE + rx;
                cy = y1 * FRAC_ONE + ry;
                kx = longint'(ELL_K) * x2;
                ky = longint'(ELL_K) * y2;
                for (int i = 0; i < 13; i++)
                    add_point(round_lsb(cx + x_offset(i, rx, kx)),
                              round_lsb(cy + y_offset(i, ry, ky)),
                              (i == 0) ? PT_START : PT_BEZIER, i == 12, i == 12);
                start_pending = 1'b1;
                last_closed   = 1'b1;
            end
            CMD_START:
                start_pending = 1'b1;
            default:
                ;
        endcase
    endtask

    task automatic check_point(input point_item_t got);
        point_item_t want;
        if (expected_points.size() == 0)
            report_mismatch($sformatf("point with nothing expected: x=%0d y=%0d kind=%02h",
                                      got.out_x, got.out_y, got.point_kind));
        else
        begin
            want = expected_points.pop_front();
            if (got.out_x !== want.out_x)
                report_mismatch($sformatf("out_x expected %0d got %0d",
                                          want.out_x, got.out_x));
            if (got.out_y !== want.out_y)
                report_mismatch($sformatf("out_y expected %0d got %0d",
                                          want.out_y, got.out_y));
            if (got.point_kind !== want.point_kind)
                report_mismatch($sformatf("point_kind expected %02h got %02h",
                                          want.point_kind, got.point_kind));
            if (got.last_of_command !== want.last_of_command)
                report_mismatch($sformatf("last_of_command expected %0b got %0b",
                                          want.last_of_command, got.last_of_command));
        end
    endtask

    // older points are checked before the new command's points are queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pending = 1'b1;
            last_closed   = 1'b0;
            expected_points.delete();
        end
        else
        begin
            if (pt_valid && !pt_stall)
                check_point(pt);
            if (cmd_valid && !cmd_stall)
                predict_points(cmd);
        end
        points_outstanding = expected_points.size();
    end

endmodule

FILE: sim/path_shape_point_emitter_tb.sv
// Testbench top for the path shape point emitter: clock, reset, command
// stimulus with bursty timing and a stalling point receiver.
// Depends on psp_pkg, path_shape_point_emitter and psp_point_checker.
module path_shape_point_emitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psp_pkg::*;

    // command codes the block must ignore
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam logic signed [COORD_W-1:0] CRD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] CRD_MIN = 24'sh800000;

    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = 16;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_item_t   cmd       = '0;
    logic        pt_valid;
    logic        pt_stall  = 1'b0;
    point_item_t pt;

    int mismatches;
    int points_outstanding;

    // sender burst bookkeeping
    int burst_left = 8;

    // receiver stall pattern: a mode held for a random span of cycles
    int stall_mode = 0;
    int stall_span = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    path_shape_point_emitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt        (pt)
    );

    psp_point_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd_valid          (cmd_valid),
        .cmd_stall          (cmd_stall),
        .cmd                (cmd),
        .pt_valid           (pt_valid),
        .pt_stall           (pt_stall),
        .pt                 (pt),
        .mismatches         (mismatches),
        .points_outstanding (points_outstanding)
    );

    // Coordinates: mostly full-range random so every bit toggles, some small
    // values so ellipses are not all saturated, and the two extremes.
    function automatic logic signed [COORD_W-1:0] random_coord();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return CRD_MAX;
            1:       return CRD_MIN;
            2, 3, 4: return COORD_W'(int'($urandom_range(0, 4095)) - 2048);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // Command mix leans toward the drawing commands; start-figure requests
    // keep exercising the forced Start type, and a few spare codes go by.
    function automatic cmd_item_t random_command();
        cmd_item_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            c.command = CMD_LINE;
        else if (pick < 40)
            c.command = CMD_BEZIER;
        else if (pick < 58)
            c.command = CMD_RECT;
        else if (pick < 80)
            c.command = CMD_ELLIPSE;
        else if (pick < 94)
            c.command = CMD_START;
        else
            c.command = 3'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI)));
        c.p1_x = random_coord();
        c.p1_y = random_coord();
        c.p2_x = random_coord();
        c.p2_y = random_coord();
        c.p3_x = random_coord();
        c.p3_y = random_coord();
        c.p4_x = random_coord();
        c.p4_y = random_coord();
        return c;
    endfunction

    function automatic cmd_item_t make_command(
        input logic [2:0]                code,
        input logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy
    );
        cmd_item_t c;
        c.command = code;
        c.p1_x    = ax;
        c.p1_y    = ay;
        c.p2_x    = bx;
        c.p2_y    = by;
        c.p3_x    = cx;
        c.p3_y    = cy;
        c.p4_x    = dx;
        c.p4_y    = dy;
        return c;
    endfunction

    // Sender idle gap of length n: valid drops and the payload is scrambled
    // meanwhile since nothing is offered.
    task automatic hold_off(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            cmd       <= random_command();
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Offer one transaction and hold it until the block takes it. Valid stays
    // high across back-to-back transactions inside a burst.
    task automatic send_command(input cmd_item_t item);
        @(negedge clk);
        cmd       <= item;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            // one gap in four is skipped, giving long unbroken stretches
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    // Stop offering and wait until every predicted point has come out.
    task automatic drain_points();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (points_outstanding != 0)
            @(negedge clk);
    endtask

    // Directed part: extremes, every command, overflow of rectangle corners,
    // rounding ties on ellipses, forced Start after start requests and after
    // closed figures, and the spare codes.
    task automatic run_directed();
        // first point after reset is forced to Start
        send_command(make_command(CMD_LINE, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MAX,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        // bezier continuing the open figure
        send_command(make_command(CMD_BEZIER, CRD_MIN, CRD_MAX, 24'sd1, -24'sd1,
                                  CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN));
        // rectangle running off the top of the range, then off the bottom
        send_command(make_command(CMD_RECT, CRD_MAX - 24'sd10, CRD_MIN + 24'sd10,
                                  24'sd100, -24'sd100,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        // line after a closed rectangle starts a new figure
        send_command(make_command(CMD_LINE, 24'sd0, 24'sd0, -24'sd1, -24'sd1,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        send_command(make_command(CMD_RECT, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        send_command(make_command(CMD_RECT, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        // start request with junk fields, then a bezier that must begin with Start
        send_command(make_command(CMD_START, CRD_MAX, CRD_MIN, CRD_MAX, CRD_MIN,
                                  CRD_MAX, CRD_MIN, CRD_MAX, CRD_MIN));
        send_command(make_command(CMD_BEZIER, 24'sd256, 24'sd512, 24'sd768, 24'sd1024,
                                  -24'sd256, -24'sd512, -24'sd768, -24'sd1024));
        // odd sizes put the center and quadrant ends on exact half-LSB ties
        send_command(make_command(CMD_ELLIPSE, -24'sd5, 24'sd3, 24'sd1, 24'sd3,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        // unit circle around the origin
        send_command(make_command(CMD_ELLIPSE, -24'sd256, -24'sd256, 24'sd512, 24'sd512,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        // extreme sizes: largest positive, most negative, mixed signs
        send_command(make_command(CMD_ELLIPSE, 24'sd0, 24'sd0, CRD_MAX, CRD_MAX,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        send_command(make_command(CMD_ELLIPSE, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        send_command(make_command(CMD_ELLIPSE, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        send_command(make_command(CMD_ELLIPSE, 24'sd7, -24'sd9, 24'sd0, 24'sd0,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        // spare codes must leave the closed-figure state untouched
        for (int code = int'(CMD_SPARE_LO); code <= int'(CMD_SPARE_HI); code++)
            send_command(make_command(3'(code), random_coord(), random_coord(),
                                      random_coord(), random_coord(),
                                      random_coord(), random_coord(),
                                      random_coord(), random_coord()));
        // first point after an ellipse is Start
        send_command(make_command(CMD_LINE, 24'sh000100, 24'sh000200,
                                  24'shFFFFFF, 24'shFFFFFF,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        // two start requests in a row, then a zero-size rectangle
        send_command(make_command(CMD_START, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                                  24'sd0, 24'sd0, 24'sd0, 24'sd0));
        send_command(make_command(CMD_START, 24'shFFFFFF, 24'shFFFFFF,
                                  24'shFFFFFF, 24'shFFFFFF,
                                  24'shFFFFFF, 24'shFFFFFF,
                                  24'shFFFFFF, 24'shFFFFFF));
        send_command(make_command(CMD_RECT, 24'sd40, -24'sd40, 24'sd0, 24'sd0,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        send_command(make_command(CMD_LINE, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
        send_command(make_command(CMD_BEZIER, random_coord(), random_coord(),
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord(),
                                  random_coord(), random_coord()));
    endtask

    // Receiver: stall pattern of its own, switching between no stall, light
    // random, heavy random and strict alternation after each random span.
    always @(negedge clk)
    begin
        if (stall_span <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(32, 200);
        end
        stall_span--;
        case (stall_mode)
            0:       pt_stall <= 1'b0;
            1:       pt_stall <= ($urandom_range(0, 3) == 0);
            2:       pt_stall <= ($urandom_range(0, 9) < 6);
            default: pt_stall <= ~pt_stall;
        endcase
    end

    // Main sequence: reset, directed commands, random commands with one full
    // drain halfway through, then final drain and verdict.
    initial
    begin
        int accepted;
        cmd_item_t item;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain_points();

        accepted = 0;
        while (accepted < RANDOM_ITEMS)
        begin
            item = random_command();
            send_command(item);
            // spare codes pass through without doing anything
            if (item.command < CMD_SPARE_LO)
                accepted++;
            if (accepted == RANDOM_ITEMS / 2)
            begin
                drain_points();
                accepted++;
            end
        end

        drain_points();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: path_shape_point_emitter.f
hdl/psp_pkg.sv
hdl/psp_front.sv
hdl/psp_queue.sv
hdl/psp_back.sv
hdl/path_shape_point_emitter.sv
sim/psp_point_checker.sv
sim/path_shape_point_emitter_tb.sv
